/* sv/tvs_pkg.sv */
// Shared constants, types and sine table builder for the three-voice tone synth.
package tvs_pkg;

    localparam int SAMPLE_RATE = 16000;
    localparam int TABLE_BITS  = 8;
    localparam int ROM_SIZE    = 2 ** TABLE_BITS;

    localparam int HZ_W       = 13;
    localparam int PHASE_W    = 16;
    localparam int SINE_W     = 16;
    localparam int SINE_AMP   = 32767;
    localparam int NUM_VOICES = 3;

    localparam int VOICE_LEAD = 0;
    localparam int VOICE_BASS = 1;
    localparam int VOICE_HARM = 2;

    // Phase step = floor(hz * 2^PHASE_W / SAMPLE_RATE), by reciprocal multiply.
    // STEP_K keeps hz * rounding error below 2^STEP_K, so the floor is exact.
    localparam int STEP_K = HZ_W + $clog2(SAMPLE_RATE);
    localparam logic [63:0] STEP_MUL_64 =
        ((64'd1 << (PHASE_W + STEP_K)) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam int STEP_MUL_W = $clog2(STEP_MUL_64 + 64'd1);
    localparam logic [STEP_MUL_W-1:0] STEP_MUL = STEP_MUL_W'(STEP_MUL_64);
    localparam logic [63:0] STEP_MAX =
        (64'(2 ** HZ_W - 1) << PHASE_W) / 64'(SAMPLE_RATE);
    localparam int STEP_W = $clog2(STEP_MAX + 64'd1);
    localparam int PROD_W = HZ_W + STEP_MUL_W;

    // Signed divide by 3 (truncating) on the magnitude, by reciprocal multiply.
    localparam int DIV3_SHIFT = SINE_W + 1;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int DIV3_MUL_W = $clog2(DIV3_MUL + 1);

    localparam int VOICE_W   = SINE_W + 2;
    localparam int MIX_W     = VOICE_W + 4;
    localparam int OUT_W     = 15;
    localparam int MIX_SHIFT = 5;
    localparam int MIX_LIMIT = 9000;
    localparam int LEAD_GAIN = 5;
    localparam int BASS_GAIN = 3;
    localparam int HARM_GAIN = 2;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef logic [HZ_W-1:0]              hz_t;
    typedef logic [STEP_W-1:0]            step_t;
    typedef logic [PHASE_W-1:0]           phase_t;
    typedef logic [TABLE_BITS-1:0]        rom_addr_t;
    typedef logic signed [SINE_W-1:0]     sine_t;
    typedef logic signed [VOICE_W-1:0]    voice_t;
    typedef logic signed [OUT_W-1:0]      sample_t;
    typedef sine_t                        sine_tbl_t [ROM_SIZE];

    typedef struct packed {
        logic      active;
        rom_addr_t idx1;
        rom_addr_t idx3;
    } rom_req_t;

    typedef struct packed {
        logic  active;
        sine_t s1;
        sine_t s3;
    } rom_rsp_t;

    // sin(2*pi*j/ROM_SIZE) in Q30 for the first quarter wave, Taylor series.
    function automatic logic [63:0] sin_q30(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int unsigned k;
        x    = ((((PI_Q60 >> 20) * (64'(j) << 1)) / ROM_SIZE) + 64'd512) >> 10;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = x;
        for (k = 1; k < 14; k++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = (sum > term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        if (sum > (64'd1 << 30)) begin
            sum = 64'd1 << 30;
        end
        return sum;
    endfunction

    // Full sine table, evaluated at elaboration only.
    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t   tbl;
        int unsigned i;
        int unsigned q;
        int unsigned r;
        int unsigned j;
        logic [63:0] mag;
        for (i = 0; i < ROM_SIZE; i++) begin
            q   = i / (ROM_SIZE / 4);
            r   = i % (ROM_SIZE / 4);
            j   = q[0] ? (ROM_SIZE / 4) - r : r;
            mag = (sin_q30(j) * 64'(SINE_AMP) + (64'd1 << 29)) >> 30;
            tbl[i] = (q >= 2) ? -sine_t'(mag) : sine_t'(mag);
        end
        return tbl;
    endfunction

endpackage

/* sv/tvs_phase_acc.sv */
// Phase step calculation and per-voice phase accumulators with sine address generation.
module tvs_phase_acc import tvs_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic                            addr_en,
    input  logic                            phase_upd,
    input  hz_t      [NUM_VOICES-1:0]       hz,
    output rom_req_t [NUM_VOICES-1:0]       req
);

    step_t    step_reg  [NUM_VOICES];
    step_t    step_next [NUM_VOICES];
    phase_t   phase_reg [NUM_VOICES];
    phase_t   phase_next[NUM_VOICES];
    rom_req_t [NUM_VOICES-1:0] req_reg;
    rom_req_t [NUM_VOICES-1:0] req_next;

    logic [PROD_W-1:0] prod   [NUM_VOICES];
    phase_t            phase3 [NUM_VOICES];
    logic              active [NUM_VOICES];

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            prod[v]      = PROD_W'(hz[v]) * PROD_W'(STEP_MUL);
            step_next[v] = prod[v][STEP_K +: STEP_W];

            // silent voice: phase holds
            active[v]     = (step_reg[v] != '0);
            phase_next[v] = active[v] ? phase_reg[v] + PHASE_W'(step_reg[v]) : phase_reg[v];
            phase3[v]     = PHASE_W'({phase_next[v], 1'b0}) + phase_next[v];

            req_next[v].active = active[v];
            req_next[v].idx1   = phase_next[v][PHASE_W-1 -: TABLE_BITS];
            req_next[v].idx3   = phase3[v][PHASE_W-1 -: TABLE_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                phase_reg[v] <= '0;
            end
        end else if (phase_upd) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                phase_reg[v] <= phase_next[v];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                step_reg[v] <= step_next[v];
            end
        end
        if (addr_en) begin
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

/* sv/tvs_sine_rom.sv */
// Sine ROM with registered read data, one fundamental and one third-harmonic port per voice.
module tvs_sine_rom import tvs_pkg::*; (
    input  logic                            aclk,
    input  logic                            rd_en,
    input  rom_req_t [NUM_VOICES-1:0]       req,
    output rom_rsp_t [NUM_VOICES-1:0]       rsp
);

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

    rom_rsp_t [NUM_VOICES-1:0] rsp_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                rsp_reg[v].active <= req[v].active;
                rsp_reg[v].s1     <= SINE_TBL[req[v].idx1];
                rsp_reg[v].s3     <= SINE_TBL[req[v].idx3];
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

/* sv/tvs_mixer.sv */
// Voice value (fundamental plus third harmonic over three), weighted mix, shift and clamp.
module tvs_mixer import tvs_pkg::*; (
    input  logic                            aclk,
    input  logic                            voice_en,
    input  logic                            out_en,
    input  rom_rsp_t [NUM_VOICES-1:0]       rsp,
    output sample_t                         sample
);

    localparam int Q3_W = SINE_W + 1 + DIV3_MUL_W;

    voice_t  voice_reg  [NUM_VOICES];
    voice_t  voice_next [NUM_VOICES];
    sample_t sample_reg;
    sample_t sample_next;

    logic signed [SINE_W:0] s3_ext  [NUM_VOICES];
    logic        [SINE_W:0] s3_mag  [NUM_VOICES];
    logic        [Q3_W-1:0] q3_prod [NUM_VOICES];
    voice_t                 q3      [NUM_VOICES];

    logic signed [MIX_W-1:0] mix_sum;
    logic signed [MIX_W-1:0] mix_shr;

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            s3_ext[v]  = (SINE_W + 1)'(rsp[v].s3);
            s3_mag[v]  = rsp[v].s3[SINE_W-1] ? -s3_ext[v] : s3_ext[v];
            q3_prod[v] = Q3_W'(s3_mag[v]) * Q3_W'(DIV3_MUL);
            q3[v]      = VOICE_W'(q3_prod[v] >> DIV3_SHIFT);
            if (rsp[v].s3[SINE_W-1]) begin
                q3[v] = -q3[v];
            end
            voice_next[v] = rsp[v].active ? VOICE_W'(rsp[v].s1) + q3[v] : '0;
        end
    end

    // floor division by 32 is the arithmetic shift
    always_comb begin
        mix_sum = MIX_W'(voice_reg[VOICE_LEAD]) * MIX_W'(LEAD_GAIN)
                + MIX_W'(voice_reg[VOICE_BASS]) * MIX_W'(BASS_GAIN)
                + MIX_W'(voice_reg[VOICE_HARM]) * MIX_W'(HARM_GAIN);
        mix_shr = mix_sum >>> MIX_SHIFT;
        if (mix_shr > MIX_LIMIT) begin
            sample_next = OUT_W'(MIX_LIMIT);
        end else if (mix_shr < -MIX_LIMIT) begin
            sample_next = OUT_W'(-MIX_LIMIT);
        end else begin
            sample_next = OUT_W'(mix_shr);
        end
    end

    always_ff @(posedge aclk) begin
        if (voice_en) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                voice_reg[v] <= voice_next[v];
            end
        end
        if (out_en) begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

/* sv/three_voice_tone_synth_mixer_top.sv */
// Top level of the three-voice DDS tone synthesiser and mixer.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_lead_hz, s_bass_hz, s_harm_hz (13 b unsigned)
//   m_        out        m_valid / m_ready  m_sample (15 b signed, clamped to +/-9000)
//
// One tick per cycle sustained while m_ready stays high; m_valid rises when the tick reaches the output register.
// The rate is set by the phase accumulator: one add per voice closes the only loop.
// Pipeline: step multiply, phase add and ROM address, ROM read, voice sum, mix and clamp.
// Reset (aresetn low, synchronous) clears the phases and the stage valid bits; the
// sine ROM is a constant table and needs no clearing pass.
// Each stage advances when it is empty or the stage after it moves, so bubbles close up
// and s_ready drops only when all five stages are full and m_ready is low.
module three_voice_tone_synth_mixer_top import tvs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  hz_t     s_lead_hz,
    input  hz_t     s_bass_hz,
    input  hz_t     s_harm_hz,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_sample
);

    localparam int NUM_STAGES = 5;
    localparam int ST_STEP    = 0;   // phase step registered
    localparam int ST_ADDR    = 1;   // phase updated, ROM addresses registered
    localparam int ST_ROM     = 2;   // ROM data registered
    localparam int ST_VOICE   = 3;   // voice values registered
    localparam int ST_OUT     = 4;   // output sample register

    logic [NUM_STAGES-1:0] stage_vld_reg;
    logic [NUM_STAGES-1:0] stage_vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    hz_t      [NUM_VOICES-1:0] hz;
    rom_req_t [NUM_VOICES-1:0] rom_req;
    rom_rsp_t [NUM_VOICES-1:0] rom_rsp;

    // Stall chain: a stage may load when it is empty or its contents move on.
    always_comb begin
        stage_en[ST_OUT] = !stage_vld_reg[ST_OUT] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !stage_vld_reg[k] || stage_en[k+1];
        end
        stage_vld_next[ST_STEP] = stage_en[ST_STEP] ? s_valid : stage_vld_reg[ST_STEP];
        for (int k = 1; k < NUM_STAGES; k++) begin
            stage_vld_next[k] = stage_en[k] ? stage_vld_reg[k-1] : stage_vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
        end else begin
            stage_vld_reg <= stage_vld_next;
        end
    end

    assign s_ready = stage_en[ST_STEP];
    assign m_valid = stage_vld_reg[ST_OUT];

    assign hz[VOICE_LEAD] = s_lead_hz;
    assign hz[VOICE_BASS] = s_bass_hz;
    assign hz[VOICE_HARM] = s_harm_hz;

    // Phases move only when a real tick leaves the step stage.
    tvs_phase_acc u_phase_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (stage_en[ST_STEP]),
        .addr_en   (stage_en[ST_ADDR]),
        .phase_upd (stage_vld_reg[ST_STEP] && stage_en[ST_ADDR]),
        .hz        (hz),
        .req       (rom_req)
    );

    tvs_sine_rom u_sine_rom (
        .aclk  (aclk),
        .rd_en (stage_en[ST_ROM]),
        .req   (rom_req),
        .rsp   (rom_rsp)
    );

    tvs_mixer u_mixer (
        .aclk     (aclk),
        .voice_en (stage_en[ST_VOICE]),
        .out_en   (stage_en[ST_OUT]),
        .rsp      (rom_rsp),
        .sample   (m_sample)
    );

    // Clamp must hold on every presented sample.
    a_sample_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample <= MIX_LIMIT && m_sample >= -MIX_LIMIT))
        else $error("mixed sample outside clamp range");

    // Input back-pressure only when every stage is occupied and the sink stalls.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&stage_vld_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // No result straight out of reset.
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

/* tb/sv/three_voice_tone_synth_mixer_top_test.sv */
// Self-checking testbench for the three-voice DDS tone synthesiser and mixer top level.
`timescale 1ns / 100ps

module three_voice_tone_synth_mixer_top_test;
    import tvs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int GAP_MAX     = 12;
    // Deepest point of the pipeline plus some slack, waited out after the last sample.
    localparam int TAIL_CYCLES = 10;

    logic    aclk      = 1'b0;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    hz_t     s_lead_hz = '0;
    hz_t     s_bass_hz = '0;
    hz_t     s_harm_hz = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    sample_t m_sample;

    // Samples predicted for transfers already accepted, oldest first.
    sample_t pending_samples [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    // When low, neither side idles: back-to-back transfers on both channels.
    bit      idle_on        = 1'b1;

    // Local copy of the synth's state.
    sine_t   wave_table [ROM_SIZE];
    phase_t  voice_phase [NUM_VOICES];

    three_voice_tone_synth_mixer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_lead_hz (s_lead_hz),
        .s_bass_hz (s_bass_hz),
        .s_harm_hz (s_harm_hz),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sample  (m_sample)
    );

    always #5 aclk = ~aclk;

    // Run-away guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("three_voice_tone_synth_mixer_top_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // sin(2*pi*j/ROM_SIZE) in Q30 over the first quarter wave; Taylor series in
    // fixed point, rounding each product, so the table matches to the last bit.
    function automatic logic [63:0] quarter_sine_q30(input int unsigned j);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] tm;
        logic [63:0] acc;
        ang    = ((((PI_Q60 >> 20) * (64'(j) * 64'd2)) / 64'(ROM_SIZE)) + 64'd512) >> 10;
        ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
        tm     = ang;
        acc    = ang;
        for (int k = 1; k < 14; k++) begin
            tm = ((tm * ang_sq + (64'd1 << 29)) >> 30) / 64'(2 * k * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = (acc > tm) ? acc - tm : 64'd0;
            end else begin
                acc = acc + tm;
            end
        end
        if (acc > (64'd1 << 30)) begin
            acc = 64'd1 << 30;
        end
        return acc;
    endfunction

    // Whole wave from the quarter by symmetry; magnitude rounded half up.
    function automatic void fill_wave_table();
        int unsigned quarter;
        int unsigned quad;
        int unsigned offs;
        logic [63:0] mag;
        quarter = ROM_SIZE / 4;
        for (int unsigned i = 0; i < ROM_SIZE; i++) begin
            quad = i / quarter;
            offs = i % quarter;
            mag  = (quarter_sine_q30((quad % 2 == 1) ? quarter - offs : offs)
                    * 64'(SINE_AMP) + (64'd1 << 29)) >> 30;
            wave_table[i] = (quad >= 2) ? -sine_t'(mag) : sine_t'(mag);
        end
    endfunction

    // Advance one voice by one tick and return its level: fundamental plus a
    // third of the third harmonic. A zero step leaves the phase frozen.
    function automatic int voice_level(input int v, input hz_t hz);
        logic [63:0] step;
        phase_t      ph;
        phase_t      ph3;
        step = (64'(hz) << PHASE_W) / 64'(SAMPLE_RATE);
        if (step == 64'd0) begin
            return 0;
        end
        ph             = phase_t'(64'(voice_phase[v]) + step);
        voice_phase[v] = ph;
        ph3            = phase_t'(32'(ph) * 32'd3);
        return int'(wave_table[ph[PHASE_W-1 -: TABLE_BITS]])
             + int'(wave_table[ph3[PHASE_W-1 -: TABLE_BITS]]) / 3;
    endfunction

    // One tick of the mixer: weighted sum, arithmetic shift, clamp.
    function automatic sample_t mix_tick(input hz_t lead, input hz_t bass, input hz_t harm);
        int lv;
        int bv;
        int hv;
        int acc;
        lv  = voice_level(VOICE_LEAD, lead);
        bv  = voice_level(VOICE_BASS, bass);
        hv  = voice_level(VOICE_HARM, harm);
        acc = (LEAD_GAIN * lv + BASS_GAIN * bv + HARM_GAIN * hv) >>> MIX_SHIFT;
        if (acc > MIX_LIMIT) begin
            acc = MIX_LIMIT;
        end else if (acc < -MIX_LIMIT) begin
            acc = -MIX_LIMIT;
        end
        return sample_t'(acc);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers and result check
    // ------------------------------------------------------------------

    // One tick on the input channel. Valid is only lowered when a gap is drawn,
    // so back-to-back transfers keep it high without a glitch.
    task automatic send_tick(input hz_t lead, input hz_t bass, input hz_t harm);
        int gap;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_lead_hz <= lead;
        s_bass_hz <= bass;
        s_harm_hz <= harm;
        do @(posedge aclk); while (!s_ready);
        pending_samples.push_back(mix_tick(lead, bass, harm));
    endtask

    // Stop sending until every predicted sample has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_samples.size() != 0);
    endtask

    // Mostly in range, with silence, very low notes and the out-of-range top end.
    function automatic hz_t pick_hz();
        case ($urandom_range(0, 9))
            0:       return hz_t'(0);
            1:       return hz_t'($urandom_range(8001, 8191));
            2:       return hz_t'($urandom_range(1, 60));
            3:       return hz_t'($urandom_range(0, 8191));
            default: return hz_t'($urandom_range(0, 8000));
        endcase
    endfunction

    // Output side: a fresh stall drawn for each sample.
    initial begin : sample_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : sample_check
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                $error("m_sample: expected no transfer, actual %0d", m_sample);
                mismatch_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_sample !== want) begin
                    $error("m_sample: expected %0d, actual %0d", want, m_sample);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset all phases agree, so three voices at 1 kHz stay in
    // step and pass eighth and five-eighth wave, where the mix clips at both rails.
    // Then silence, the lowest audible step, the edges of the field and above 8 kHz.
    task automatic test_directed_extremes();
        for (int i = 0; i < 12; i++) begin
            send_tick(hz_t'(1000), hz_t'(1000), hz_t'(1000));
        end
        send_tick(hz_t'(0), hz_t'(0), hz_t'(0));
        send_tick(hz_t'(1), hz_t'(0), hz_t'(0));
        send_tick(hz_t'(0), hz_t'(1), hz_t'(0));
        send_tick(hz_t'(0), hz_t'(0), hz_t'(1));
        send_tick(hz_t'(8000), hz_t'(8000), hz_t'(8000));
        send_tick(hz_t'(8191), hz_t'(8191), hz_t'(8191));
        send_tick(hz_t'(4000), hz_t'(0), hz_t'(8191));
        send_tick(hz_t'(0), hz_t'(8191), hz_t'(4000));
        send_tick(hz_t'(0), hz_t'(0), hz_t'(0));
    endtask

    // Independent random values on every tick.
    task automatic test_random_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_tick(pick_hz(), pick_hz(), pick_hz());
        end
    endtask

    // Held notes, as a melody would play them: each chord lasts a while so the
    // phases run through whole cycles; voices drop out now and then.
    task automatic test_held_notes(input int count);
        int   sent;
        int   hold;
        hz_t  lead;
        hz_t  bass;
        hz_t  harm;
        sent = 0;
        while (sent < count) begin
            idle_on = ($urandom_range(0, 3) != 0);
            lead    = ($urandom_range(0, 7) == 0) ? hz_t'(0) : pick_hz();
            bass    = ($urandom_range(0, 5) == 0) ? hz_t'(0) : hz_t'($urandom_range(1, 1000));
            harm    = ($urandom_range(0, 5) == 0) ? hz_t'(0) : pick_hz();
            hold    = $urandom_range(1, 40);
            for (int i = 0; i < hold; i++) begin
                send_tick(lead, bass, harm);
            end
            sent += hold;
        end
    endtask

    // Sender goes quiet until the pipeline is empty, then resumes mid-note.
    task automatic test_drain_pause();
        idle_on = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_tick(hz_t'(440), hz_t'(110), hz_t'(660));
        end
        hold_until_drained();
        idle_on = 1'b0;
        for (int i = 0; i < 30; i++) begin
            send_tick(hz_t'(440), hz_t'(110), hz_t'(660));
        end
        hold_until_drained();
    endtask

    initial begin
        fill_wave_table();
        for (int v = 0; v < NUM_VOICES; v++) begin
            voice_phase[v] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_extremes();
        test_drain_pause();
        test_random_ticks(250);
        test_held_notes(1300);

        // All sent; let the last samples out, then a few idle cycles.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("three_voice_tone_synth_mixer_top_test: PASS");
        end else begin
            $display("three_voice_tone_synth_mixer_top_test: FAIL");
        end
        $finish;
    end

endmodule
